/* src/kvt_pkg.sv */
// Shared types, constants and per-side scan functions for the key/value tokenizer.
package kvt_pkg;

  localparam int unsigned DEF_MAX_PAIRS      = 32;
  localparam int unsigned DEF_MAX_TEXT_CHARS = 65536;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [30:0] NUM_MAX   = 31'h7FFFFFFF;

  localparam logic [15:0] CH_TAB   = 16'd9;
  localparam logic [15:0] CH_LF    = 16'd10;
  localparam logic [15:0] CH_CR    = 16'd13;
  localparam logic [15:0] CH_SPACE = 16'd32;
  localparam logic [15:0] CH_COMMA = 16'd44;
  localparam logic [15:0] CH_SEMI  = 16'd59;
  localparam logic [15:0] CH_COLON = 16'd58;
  localparam logic [15:0] CH_EQUAL = 16'd61;
  localparam logic [15:0] CH_MINUS = 16'd45;
  localparam logic [15:0] CH_DOT   = 16'd46;
  localparam logic [15:0] CH_PCT   = 16'd37;
  localparam logic [15:0] CH_0     = 16'd48;
  localparam logic [15:0] CH_9     = 16'd57;
  localparam logic [7:0]  CH_UC_A  = 8'd65;
  localparam logic [7:0]  CH_UC_Z  = 8'd90;

  typedef enum logic [2:0] {
    PH_KEYWAIT, PH_KEY, PH_AFTERKEY, PH_VALWAIT, PH_VAL, PH_AFTERVAL
  } phase_t;

  typedef enum logic [1:0] {CL_WORD, CL_SPACE, CL_SEP, CL_EQ} char_class_t;

  typedef enum logic [2:0] {NS_FRESH, NS_INT, NS_FRAC, NS_PCT, NS_BAD} num_step_t;

  typedef enum logic [1:0] {
    KIND_PAIR, KIND_DONE, KIND_SYNTAX, KIND_TOOMANY
  } kind_t;

  typedef enum logic [1:0] {KT_STRING, KT_NUMBER, KT_PERCENT} num_type_t;

  typedef struct packed {
    logic [15:0] start;
    logic [16:0] count;
    logic [63:0] hash;
    logic [30:0] number;
    num_step_t   step;
    logic        neg;
    logic [1:0]  fcnt;
    logic [6:0]  fval;
  } side_t;

  typedef struct packed {
    num_type_t   vtype;
    logic [31:0] v;
  } side_val_t;

  typedef struct packed {
    kind_t              result_kind;
    logic [16:0]        start_offset;
    logic [16:0]        key_length;
    logic [1:0]         key_type;
    logic [63:0]        key_hash;
    logic signed [31:0] key_number;
    logic [1:0]         value_type;
    logic [15:0]        value_offset;
    logic [16:0]        value_length;
    logic [63:0]        value_hash;
    logic signed [31:0] value_number;
    logic               last_result;
  } result_t;

  function automatic char_class_t classify(input logic [15:0] c);
    if (c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_SPACE) return CL_SPACE;
    if (c == CH_COMMA || c == CH_SEMI) return CL_SEP;
    if (c == CH_COLON || c == CH_EQUAL) return CL_EQ;
    return CL_WORD;
  endfunction

  function automatic side_t side_begin(input logic [15:0] pos);
    side_t s;
    s = '0;
    s.start = pos;
    s.hash = FNV_BASIS;
    s.step = NS_FRESH;
    return s;
  endfunction

  // prime is 2^40 + 0x1B3, so the multiply is a handful of shifted adds
  function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  function automatic side_t side_add(input side_t s_in, input logic [15:0] c);
    side_t       s;
    logic [7:0]  b;
    logic        digit;
    logic [3:0]  d;
    logic [34:0] t;
    logic [6:0]  fv;
    s = s_in;
    b = c[7:0];
    digit = (c >= CH_0) && (c <= CH_9);
    d = digit ? 4'(c - CH_0) : 4'd0;
    if (b >= CH_UC_A && b <= CH_UC_Z) b = b + 8'd32;
    s.hash = fnv_mix(s.hash, b);
    s.count = s.count + 17'd1;
    if (s.step == NS_FRESH && c == CH_MINUS) begin
      s.step = NS_INT;
      s.neg = 1'b1;
    end else begin
      if (s.step == NS_FRESH) s.step = NS_INT;
      unique case (s.step)
        NS_INT: begin
          if (digit) begin
            t = 35'({s.number, 3'b000}) + 35'({s.number, 1'b0}) + 35'(d);
            s.number = (t > 35'(NUM_MAX)) ? NUM_MAX : t[30:0];
          end else if (c == CH_DOT) s.step = NS_FRAC;
          else if (c == CH_PCT) s.step = NS_PCT;
          else s.step = NS_BAD;
        end
        NS_FRAC: begin
          if (digit) begin
            if (s.fcnt < 2'd2) begin
              fv = 7'({s.fval, 3'b000}) + 7'({s.fval, 1'b0}) + 7'(d);
              s.fval = fv;
              s.fcnt = s.fcnt + 2'd1;
            end
          end else if (c == CH_PCT) s.step = NS_PCT;
          else s.step = NS_BAD;
        end
        default: s.step = NS_BAD;
      endcase
    end
    return s;
  endfunction

  function automatic side_val_t side_value(input side_t s);
    side_val_t   r;
    logic [6:0]  fv;
    logic [37:0] t;
    logic [30:0] mag;
    r = '0;
    if (s.step == NS_BAD || s.step == NS_FRESH) return r;
    if (s.step == NS_PCT) begin
      // a single fraction digit counts as tens
      fv = (s.fcnt == 2'd1) ? 7'({s.fval, 3'b000}) + 7'({s.fval, 1'b0}) : s.fval;
      t = 38'({s.number, 6'b0}) + 38'({s.number, 5'b0}) + 38'({s.number, 2'b0})
        + 38'(fv);
      mag = (t > 38'(NUM_MAX)) ? NUM_MAX : t[30:0];
      r.vtype = KT_PERCENT;
    end else begin
      mag = s.number;
      r.vtype = KT_NUMBER;
    end
    r.v = s.neg ? (32'd0 - {1'b0, mag}) : {1'b0, mag};
    return r;
  endfunction

  function automatic result_t plain_row(input kind_t kind, input logic [16:0] pos,
                                        input logic last);
    result_t r;
    r = '0;
    r.result_kind = kind;
    r.start_offset = pos;
    r.last_result = last;
    return r;
  endfunction

  function automatic result_t pair_row(input side_t k, input side_t v,
                                       input logic has_value, input logic last);
    result_t   r;
    side_val_t sv;
    r = plain_row(KIND_PAIR, {1'b0, k.start}, last);
    r.key_length = k.count;
    if (has_value) begin
      r.key_hash = k.hash;
      r.value_offset = v.start;
      r.value_length = v.count;
      sv = side_value(v);
      if (sv.vtype == KT_STRING) begin
        r.value_type = 2'd1;
        r.value_hash = v.hash;
      end else begin
        r.value_type = 2'(sv.vtype) + 2'd1;
        r.value_number = sv.v;
      end
    end else begin
      sv = side_value(k);
      r.key_type = 2'(sv.vtype);
      if (sv.vtype == KT_STRING) r.key_hash = k.hash;
      else r.key_number = sv.v;
    end
    return r;
  endfunction

endpackage

/* src/kvt_in_if.sv */
// Character input channel.
interface kvt_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_code;
  logic        end_of_text;
  modport source (output valid, char_code, end_of_text, input ready);
  modport sink (input valid, char_code, end_of_text, output ready);
endinterface

/* src/kvt_out_if.sv */
// Result output channel.
interface kvt_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic [16:0]        start_offset;
  logic [16:0]        key_length;
  logic [1:0]         key_type;
  logic [63:0]        key_hash;
  logic signed [31:0] key_number;
  logic [1:0]         value_type;
  logic [15:0]        value_offset;
  logic [16:0]        value_length;
  logic [63:0]        value_hash;
  logic signed [31:0] value_number;
  logic               last_result;
  modport source (output valid, result_kind, start_offset, key_length, key_type, key_hash,
                  key_number, value_type, value_offset, value_length, value_hash,
                  value_number, last_result, input ready);
  modport sink (input valid, result_kind, start_offset, key_length, key_type, key_hash,
                key_number, value_type, value_offset, value_length, value_hash,
                value_number, last_result, output ready);
endinterface

/* src/kvt_parser.sv */
// Parse state and per-character update; yields up to two result rows per item.
module kvt_parser import kvt_pkg::*; #(
  parameter int unsigned MAX_PAIRS      = DEF_MAX_PAIRS,
  parameter int unsigned MAX_TEXT_CHARS = DEF_MAX_TEXT_CHARS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [15:0] char_code,
  input  logic        end_of_text,
  output logic [1:0]  push_n,
  output result_t     rows [2]
);

  phase_t      ph, ph_next;
  logic [16:0] pos, pos_next;
  side_t       ks, ks_next, vs, vs_next;
  logic [5:0]  pe, pe_next;
  logic        err, err_next;
  char_class_t cl;
  result_t     row;
  logic [1:0]  n;

  always_comb begin
    ph_next = ph; pos_next = pos; ks_next = ks; vs_next = vs;
    pe_next = pe; err_next = err; n = 2'd0;
    rows[0] = '0; rows[1] = '0;
    row = '0;
    cl = classify(char_code);
    if (take) begin
      if (!err && pos < 17'(MAX_TEXT_CHARS)) begin
        unique case (ph)
          PH_KEY: begin
            if (cl == CL_WORD) ks_next = side_add(ks, char_code);
            else if (cl == CL_SPACE) ph_next = PH_AFTERKEY;
            else if (cl == CL_EQ) ph_next = PH_VALWAIT;
            else begin
              row = pair_row(ks, vs, 1'b0, 1'b0);
              if (pe_next >= 6'(MAX_PAIRS)) begin
                row = plain_row(KIND_TOOMANY, 17'd0, 1'b1); err_next = 1'b1;
              end else pe_next = pe_next + 6'd1;
              rows[n[0]] = row; n = n + 2'd1;
              ph_next = PH_KEYWAIT;
            end
          end
          PH_AFTERKEY: begin
            if (cl == CL_EQ) ph_next = PH_VALWAIT;
            else if (cl == CL_SEP || cl == CL_WORD) begin
              row = pair_row(ks, vs, 1'b0, 1'b0);
              if (pe_next >= 6'(MAX_PAIRS)) begin
                row = plain_row(KIND_TOOMANY, 17'd0, 1'b1); err_next = 1'b1;
              end else pe_next = pe_next + 6'd1;
              rows[n[0]] = row; n = n + 2'd1;
              if (cl == CL_SEP) ph_next = PH_KEYWAIT;
              else if (!err_next) begin
                ks_next = side_add(side_begin(pos[15:0]), char_code);
                ph_next = PH_KEY;
              end
            end
          end
          PH_VALWAIT: begin
            if (cl == CL_WORD) begin
              vs_next = side_add(side_begin(pos[15:0]), char_code);
              ph_next = PH_VAL;
            end else if (cl != CL_SPACE) begin
              rows[n[0]] = plain_row(KIND_SYNTAX, pos, 1'b1); n = n + 2'd1;
              err_next = 1'b1;
            end
          end
          PH_VAL, PH_AFTERVAL: begin
            if (cl == CL_WORD && ph == PH_VAL) vs_next = side_add(vs, char_code);
            else if (cl == CL_SPACE) ph_next = PH_AFTERVAL;
            else begin
              row = pair_row(ks, vs, 1'b1, 1'b0);
              if (pe_next >= 6'(MAX_PAIRS)) begin
                row = plain_row(KIND_TOOMANY, 17'd0, 1'b1); err_next = 1'b1;
              end else pe_next = pe_next + 6'd1;
              rows[n[0]] = row; n = n + 2'd1;
              if (cl == CL_SEP) ph_next = PH_KEYWAIT;
              else if (!err_next) begin
                if (cl == CL_WORD) begin
                  ks_next = side_add(side_begin(pos[15:0]), char_code);
                  ph_next = PH_KEY;
                end else begin
                  // '=' straight after a value
                  rows[n[0]] = plain_row(KIND_SYNTAX, pos, 1'b1); n = n + 2'd1;
                  err_next = 1'b1;
                end
              end
            end
          end
          default: begin
            ph_next = PH_KEYWAIT;
            if (cl == CL_WORD) begin
              ks_next = side_add(side_begin(pos[15:0]), char_code);
              ph_next = PH_KEY;
            end else if (cl != CL_SPACE) begin
              rows[n[0]] = plain_row(KIND_SYNTAX, pos, 1'b1); n = n + 2'd1;
              err_next = 1'b1;
            end
          end
        endcase
        pos_next = pos + 17'd1;
      end
      if (end_of_text) begin
        if (!err_next) begin
          if (ph_next == PH_KEY || ph_next == PH_AFTERKEY ||
              ph_next == PH_VAL || ph_next == PH_AFTERVAL) begin
            row = pair_row(ks_next, vs_next,
                           (ph_next == PH_VAL || ph_next == PH_AFTERVAL), 1'b1);
            if (pe_next >= 6'(MAX_PAIRS)) row = plain_row(KIND_TOOMANY, 17'd0, 1'b1);
            rows[n[0]] = row;
          end else if (ph_next == PH_VALWAIT) begin
            rows[n[0]] = plain_row(KIND_SYNTAX, pos_next, 1'b1);
          end else begin
            rows[n[0]] = plain_row(KIND_DONE, pos_next, 1'b1);
          end
          n = n + 2'd1;
        end
        ph_next = PH_KEYWAIT; pos_next = '0; pe_next = '0; err_next = 1'b0;
        ks_next = side_begin(16'd0); vs_next = side_begin(16'd0);
      end
    end
    push_n = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= PH_KEYWAIT;
      pos <= '0;
      pe <= '0;
      err <= 1'b0;
      ks <= side_begin(16'd0);
      vs <= side_begin(16'd0);
    end else begin
      ph <= ph_next;
      pos <= pos_next;
      pe <= pe_next;
      err <= err_next;
      ks <= ks_next;
      vs <= vs_next;
    end
  end

  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    take && end_of_text |=> ph == PH_KEYWAIT && pos == 17'd0 && !err)
    else $error("state not cleared after end of text");
  a_pairs_bound: assert property (@(posedge clk) disable iff (rst)
    pe <= 6'(MAX_PAIRS))
    else $error("pair count above limit");
  a_err_silent: assert property (@(posedge clk) disable iff (rst)
    take && err && !end_of_text |-> push_n == 2'd0)
    else $error("result after latched error");

endmodule

/* src/kvt_outq.sv */
// Four-entry result queue; takes up to two rows per cycle, hands out one when ready is high.
module kvt_outq import kvt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_n,
  input  result_t    rows [2],
  output logic       room,
  output logic       valid,
  input  logic       ready,
  output result_t    head
);

  result_t    mem [4];
  logic [1:0] wp, rp;
  logic [2:0] count;
  logic       pop;

  assign pop   = valid && ready;
  assign valid = (count != 3'd0);
  assign room  = (count <= 3'd2);
  assign head  = mem[rp];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wp] <= rows[0];
    if (push_n == 2'd2) mem[wp + 2'd1] <= rows[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      wp <= wp + push_n;
      if (pop) rp <= rp + 2'd1;
      count <= count + 3'(push_n) - 3'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count + 3'(push_n) <= 3'd4 + 3'(pop))
    else $error("result queue overflow");
  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("queue count out of range");
  a_rp_step: assert property (@(posedge clk) disable iff (rst)
    pop |=> rp == $past(rp) + 2'd1)
    else $error("read pointer did not advance");

endmodule

/* src/key_value_text_tokenizer_top.sv */
// Each result is registered into the result queue as its character is taken.
// One character per cycle while the queue has room; a character yields zero, one or two results,
// and a four-entry result queue takes input while at most two results wait in it.
// Input stalls only when the queue holds three or more results.
// Reset (rst, synchronous): parser back to waiting for a key, queue empty.
// Parser state also returns to reset after every end-of-text character.
module key_value_text_tokenizer_top import kvt_pkg::*; #(
  parameter int unsigned MAX_PAIRS      = DEF_MAX_PAIRS,
  parameter int unsigned MAX_TEXT_CHARS = DEF_MAX_TEXT_CHARS
) (
  input logic     clk,
  input logic     rst,
  kvt_in_if.sink  in,
  kvt_out_if.source out
);

  logic       take, room;
  logic [1:0] push_n;
  result_t    rows [2];
  result_t    head;

  assign in.ready = room;
  assign take = in.valid && room;

  kvt_parser #(.MAX_PAIRS(MAX_PAIRS), .MAX_TEXT_CHARS(MAX_TEXT_CHARS)) u_parser (
    .clk(clk), .rst(rst), .take(take), .char_code(in.char_code),
    .end_of_text(in.end_of_text), .push_n(push_n), .rows(rows)
  );

  kvt_outq u_outq (
    .clk(clk), .rst(rst), .push_n(push_n), .rows(rows), .room(room),
    .valid(out.valid), .ready(out.ready), .head(head)
  );

  assign out.result_kind  = 2'(head.result_kind);
  assign out.start_offset = head.start_offset;
  assign out.key_length   = head.key_length;
  assign out.key_type     = head.key_type;
  assign out.key_hash     = head.key_hash;
  assign out.key_number   = head.key_number;
  assign out.value_type   = head.value_type;
  assign out.value_offset = head.value_offset;
  assign out.value_length = head.value_length;
  assign out.value_hash   = head.value_hash;
  assign out.value_number = head.value_number;
  assign out.last_result  = head.last_result;

endmodule
